// ===== rtl/ks_pkg.sv =====
// Shared types and constants for the Kalai-Smorodinsky point selector.
// Used by the channel interfaces, the divider lanes, the merge stage and the top level.
package ks_pkg;

   // objective values, nadir and shadow coordinates
   localparam int VAL_W = 32;
   // 1-based result index, point counter
   localparam int CNT_W = 17;
   // 0-based stored index
   localparam int IDX_W = 16;
   // objective slots carried by one beat
   localparam int OBJ_SLOTS = 4;
   localparam int SLOT_W = $clog2(OBJ_SLOTS);
   // exact difference of two values
   localparam int DIFF_W = VAL_W + 1;

   // register map
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_NADIR_0  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SHADOW_0 = CSR_IDX_W'(OBJ_SLOTS);
   localparam logic [CSR_IDX_W-1:0] REG_END      = CSR_IDX_W'(2 * OBJ_SLOTS);

   localparam logic signed [VAL_W-1:0] NADIR_RESET  = '0;
   localparam logic signed [VAL_W-1:0] SHADOW_RESET = VAL_W'(65536);

   localparam logic signed [VAL_W-1:0] SAT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] SAT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   // what one lane found for its objective
   typedef struct packed {
      logic                    skip;
      logic signed [VAL_W-1:0] ratio;
   } ks_lane_res_type;

   // merge stage control from the sequencer
   typedef struct packed {
      logic load_min;
      logic commit;
      logic last;
   } ks_merge_ctl_type;

   // result of a finished set
   typedef struct packed {
      logic [CNT_W-1:0]        best_index;
      logic signed [VAL_W-1:0] best_score;
      logic                    count_overflow;
   } ks_result_type;

endpackage

// ===== rtl/ks_if.sv =====
// Valid/ready channel interfaces: candidate points, results and register writes.
// Depends on ks_pkg for field widths.
interface ks_req_if;
   logic                            valid;
   logic                            ready;
   logic signed [ks_pkg::VAL_W-1:0] obj_0;
   logic signed [ks_pkg::VAL_W-1:0] obj_1;
   logic signed [ks_pkg::VAL_W-1:0] obj_2;
   logic signed [ks_pkg::VAL_W-1:0] obj_3;
   logic                            last_point;

   modport source (output valid, obj_0, obj_1, obj_2, obj_3, last_point, input ready);
   modport sink   (input valid, obj_0, obj_1, obj_2, obj_3, last_point, output ready);
endinterface

interface ks_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ks_pkg::CNT_W-1:0]        best_index;
   logic signed [ks_pkg::VAL_W-1:0] best_score;
   logic                            count_overflow;

   modport source (output valid, best_index, best_score, count_overflow, input ready);
   modport sink   (input valid, best_index, best_score, count_overflow, output ready);
endinterface

interface ks_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ks_pkg::CSR_IDX_W-1:0] index;
   logic [ks_pkg::VAL_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ks_lane.sv =====
// One objective lane: forms value-nadir over shadow-nadir with a radix-2 restoring
// divider, one quotient bit per cycle, and saturates the result. Depends on ks_pkg.
module ks_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [ks_pkg::VAL_W-1:0] obj,
   input  logic signed [ks_pkg::VAL_W-1:0] nadir,
   input  logic signed [ks_pkg::VAL_W-1:0] shadow,
   output logic                            done,
   output ks_pkg::ks_lane_res_type         res
);
   import ks_pkg::*;

   localparam int WIDE_W = 2 * VAL_W + 1;
   localparam int STEP_W = $clog2(VAL_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

   logic signed [DIFF_W-1:0] num;
   logic signed [DIFF_W-1:0] den;
   logic [DIFF_W-1:0]        num_mag;
   logic [DIFF_W-1:0]        den_mag;
   logic [WIDE_W-1:0]        wide_num;
   logic [WIDE_W-1:0]        wide_lim;
   logic [DIFF_W:0]          rem_sh;
   logic [DIFF_W:0]          rem_diff;
   logic                     rem_ge;

   logic [DIFF_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0]  low_ff;
   logic [DIFF_W-1:0] md_ff;
   logic [VAL_W-1:0]  q_ff;
   logic              neg_ff;
   logic              sat_ff;
   logic              zero_ff;
   logic              num_zero_ff;
   logic              num_neg_ff;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // exact differences and magnitudes
   always_comb begin
      num      = {obj[VAL_W-1], obj} - {nadir[VAL_W-1], nadir};
      den      = {shadow[VAL_W-1], shadow} - {nadir[VAL_W-1], nadir};
      num_mag  = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
      den_mag  = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
      wide_num = WIDE_W'(num_mag) << FRAC_BITS;
      // quotient reaches 2^32 exactly when the shifted numerator reaches this bound
      wide_lim = WIDE_W'(den_mag) << VAL_W;
   end

   // one restoring step
   always_comb begin
      rem_sh   = {rem_ff, low_ff[VAL_W-1]};
      rem_ge   = rem_sh >= {1'b0, md_ff};
      rem_diff = rem_sh - {1'b0, md_ff};
      rem_in   = rem_ge ? rem_diff[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
   end

   // sequence the steps
   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      step_in = step_ff;
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         step_in = '0;
      end else if (run_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // load operands, then shift one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff      <= wide_num[WIDE_W-1:VAL_W];
         low_ff      <= wide_num[VAL_W-1:0];
         md_ff       <= den_mag;
         q_ff        <= '0;
         neg_ff      <= num[DIFF_W-1] ^ den[DIFF_W-1];
         sat_ff      <= wide_num >= wide_lim;
         zero_ff     <= den == '0;
         num_zero_ff <= num == '0;
         num_neg_ff  <= num[DIFF_W-1];
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[VAL_W-2:0], 1'b0};
         q_ff   <= {q_ff[VAL_W-2:0], rem_ge};
      end
   end

   // saturate by sign
   always_comb begin
      res.skip  = 1'b0;
      res.ratio = SAT_MAX;
      if (zero_ff) begin
         res.skip  = num_zero_ff;
         res.ratio = num_neg_ff ? SAT_MIN : SAT_MAX;
      end else if (sat_ff) begin
         res.ratio = neg_ff ? SAT_MIN : SAT_MAX;
      end else if (neg_ff) begin
         res.ratio = q_ff[VAL_W-1] ? SAT_MIN : VAL_W'(-q_ff);
      end else begin
         res.ratio = q_ff[VAL_W-1] ? SAT_MAX : q_ff;
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/ks_merge.sv =====
// Merge stage: minimum over the lane ratios, then running maximum with its index,
// point counter and overflow flag. Depends on ks_pkg.
module ks_merge #(
   parameter int NUM_OBJ    = 4,
   parameter int MAX_POINTS = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ks_pkg::ks_merge_ctl_type ctl,
   input  ks_pkg::ks_lane_res_type lane_res [NUM_OBJ],
   output ks_pkg::ks_result_type   result
);
   import ks_pkg::*;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

   logic signed [VAL_W-1:0] min_in;
   logic signed [VAL_W-1:0] min_ff;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    have_ff, have_in;
   logic                    ovf_ff, ovf_in;
   logic                    full;
   logic                    take;

   // minimum over the lanes that take part
   always_comb begin
      min_in = SAT_MAX;
      for (int j = 0; j < NUM_OBJ; j++) begin
         if (!lane_res[j].skip && (lane_res[j].ratio < min_in)) begin
            min_in = lane_res[j].ratio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_min) begin
         min_ff <= min_in;
      end
   end

   // fold this point into the running best; drop it once the set is full
   always_comb begin
      full     = count_ff >= MAX_CNT;
      take     = !full && (!have_ff || (min_ff > best_ff));
      best_in  = take ? min_ff : best_ff;
      idx_in   = take ? count_ff[IDX_W-1:0] : idx_ff;
      have_in  = have_ff | take;
      count_in = full ? count_ff : count_ff + 1'b1;
      ovf_in   = ovf_ff | full;
      result.best_index     = CNT_W'(idx_in) + 1'b1;
      result.best_score     = best_in;
      result.count_overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (ctl.commit && ctl.last)) begin
         count_ff <= '0;
         best_ff  <= SAT_MIN;
         idx_ff   <= '0;
         have_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (ctl.commit) begin
         count_ff <= count_in;
         best_ff  <= best_in;
         idx_ff   <= idx_in;
         have_ff  <= have_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== rtl/kalai_smorodinsky_select.sv =====
// Top level of the Kalai-Smorodinsky point selector: registers, sequencer,
// divider lanes and merge stage. Depends on ks_pkg, ks_if, ks_lane, ks_merge.
//
//   channel  dir  beat carries
//   req      in   obj_0..obj_3, last_point (one candidate point)
//   rsp      out  best_index, best_score, count_overflow (end of set)
//   csr      in   index, data (register write, always ready)
//
// Between one accept and the next a point passes through a load of the operands, 32
// quotient steps of the radix-2 divider in each lane, the lane minimum and the fold
// into the running best; a new point is accepted only once the last one is folded.
// Reset is synchronous and clears the sequencer, the set state and the registers.
// A point that ends a set waits in the fold cycle while the previous result is
// still unread; a new point is taken in while a result waits.
module kalai_smorodinsky_select #(
   parameter int NUM_OBJ    = 4,
   parameter int MAX_POINTS = 65536,
   parameter int FRAC_BITS  = 16
) (
   input logic    clock,
   input logic    reset,
   ks_req_if.sink   req,
   ks_rsp_if.source rsp,
   ks_csr_if.sink   csr
);
   import ks_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      last_ff;

   logic signed [VAL_W-1:0] nadir_ff  [OBJ_SLOTS];
   logic signed [VAL_W-1:0] shadow_ff [OBJ_SLOTS];
   logic signed [VAL_W-1:0] obj_arr   [OBJ_SLOTS];

   ks_lane_res_type  lane_res  [NUM_OBJ];
   logic [NUM_OBJ-1:0] lane_done;
   ks_merge_ctl_type merge_ctl;
   ks_result_type    merge_res;

   logic                    rsp_valid_ff;
   logic [CNT_W-1:0]        rsp_index_ff;
   logic signed [VAL_W-1:0] rsp_score_ff;
   logic                    rsp_ovf_ff;

   logic req_beat;
   logic slot_free;
   logic csr_beat;

   assign req.ready = state_ff == ST_IDLE;
   assign req_beat  = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;
   assign csr_beat  = csr.valid && csr.ready;

   assign obj_arr[0] = req.obj_0;
   assign obj_arr[1] = req.obj_1;
   assign obj_arr[2] = req.obj_2;
   assign obj_arr[3] = req.obj_3;

   // register writes; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < OBJ_SLOTS; j++) begin
            nadir_ff[j]  <= NADIR_RESET;
            shadow_ff[j] <= SHADOW_RESET;
         end
      end else if (csr_beat) begin
         if (csr.index < REG_SHADOW_0) begin
            nadir_ff[SLOT_W'(csr.index - REG_NADIR_0)] <= csr.data;
         end else if (csr.index < REG_END) begin
            shadow_ff[SLOT_W'(csr.index - REG_SHADOW_0)] <= csr.data;
         end
      end
   end

   // one divider lane per objective
   for (genvar g = 0; g < NUM_OBJ; g++) begin : g_lane
      ks_lane #(
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .start (req_beat),
         .obj   (obj_arr[g]),
         .nadir (nadir_ff[g]),
         .shadow(shadow_ff[g]),
         .done  (lane_done[g]),
         .res   (lane_res[g])
      );
   end

   always_comb begin
      merge_ctl.load_min = (state_ff == ST_RUN) && (&lane_done);
      merge_ctl.commit   = (state_ff == ST_COMMIT) && (!last_ff || slot_free);
      merge_ctl.last     = last_ff;
   end

   ks_merge #(
      .NUM_OBJ   (NUM_OBJ),
      .MAX_POINTS(MAX_POINTS)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (merge_ctl),
      .lane_res(lane_res),
      .result  (merge_res)
   );

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the taken result unless a new one lands in the same cycle
         if (rsp_valid_ff && rsp.ready && !(merge_ctl.commit && last_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  last_ff  <= req.last_point;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (&lane_done) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (merge_ctl.commit) begin
                  if (last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_index_ff <= merge_res.best_index;
                     rsp_score_ff <= merge_res.best_score;
                     rsp_ovf_ff   <= merge_res.count_overflow;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.best_index     = rsp_index_ff;
   assign rsp.best_score     = rsp_score_ff;
   assign rsp.count_overflow = rsp_ovf_ff;

endmodule
